// ===== hdl/sllr_pkg.sv =====
`default_nettype none

package sllr_pkg;

    // Default depth of the timestamp log.
    localparam int DEF_LOG_DEPTH = 10;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int MAX_W   = 4;
    localparam int HELD_W  = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 2'd1;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;
    localparam logic [MAX_W-1:0]  MAX_RESET    = 4'd10;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_CHECK  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic check;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic log_empty;
        logic last_entry;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/sllr_ram.sv =====
`default_nettype none

module sllr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/sllr_ctrl.sv =====
`default_nettype none

module sllr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire sllr_pkg::t_status i_status,
    output sllr_pkg::t_cmd         o_cmd,
    output logic                   o_in_stall
);

    import sllr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.check  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_status.log_empty ? S_DECIDE : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.last_entry ? S_DECIDE : S_FETCH;
            end
            S_DECIDE: begin
                // Wait here until the result register can take the outcome.
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/sllr_datapath.sv =====
`default_nettype none

module sllr_datapath #(
    parameter int LOG_DEPTH = sllr_pkg::DEF_LOG_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sllr_pkg::t_cmd                 i_cmd,
    output sllr_pkg::t_status                   o_status,
    input  wire logic [sllr_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic                           i_cfg_we,
    input  wire logic [sllr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sllr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_allowed,
    output logic [sllr_pkg::HELD_W-1:0]         o_entries_held
);

    import sllr_pkg::*;

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int LW = (CW > MAX_W) ? CW : MAX_W;

    logic [TIME_W-1:0] r_window;
    logic [MAX_W-1:0]  r_max;
    logic [CW-1:0]     r_count;
    logic              r_out_valid;

    logic [TIME_W-1:0] r_now;
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     r_kept;
    logic              r_allowed;
    logic [HELD_W-1:0] r_entries;

    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] age;
    logic              keep;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     max_ext;
    logic [LW-1:0]     depth_ext;
    logic              room;
    logic [CW-1:0]     n_count;
    logic [LW-1:0]     count_ext;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_data;

    // Wrapping age of the entry just read; it stays in the log while younger
    // than the window.
    assign age  = r_now - rd_data;
    assign keep = (age < r_window);

    assign max_ext   = LW'(r_max);
    assign depth_ext = LW'(LOG_DEPTH);
    assign limit     = (max_ext > depth_ext) ? depth_ext : max_ext;
    assign room      = (LW'(r_kept) < limit);
    assign n_count   = room ? CW'(r_kept + 1'b1) : r_kept;
    assign count_ext = LW'(n_count);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_kept[AW-1:0];
        wr_data = rd_data;
        if (i_cmd.commit) begin
            wr_en   = room;
            wr_data = r_now;
        end else if (i_cmd.check) begin
            wr_en = keep;
        end
    end

    sllr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_max       <= MAX_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_MS:    r_window <= i_cfg_data[TIME_W-1:0];
                    CFG_MAX_REQUESTS: r_max    <= i_cfg_data[MAX_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now    <= i_now_ms;
            r_rd_idx <= '0;
            r_kept   <= '0;
        end
        if (i_cmd.check) begin
            r_rd_idx <= CW'(r_rd_idx + 1'b1);
            if (keep) begin
                r_kept <= CW'(r_kept + 1'b1);
            end
        end
        if (i_cmd.commit) begin
            r_allowed <= room;
            r_entries <= count_ext[HELD_W-1:0];
        end
    end

    assign o_status.log_empty  = (r_count == '0);
    assign o_status.last_entry = (CW'(r_rd_idx + 1'b1) == r_count);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_allowed      = r_allowed;
    assign o_entries_held = r_entries;

endmodule

`default_nettype wire

// ===== hdl/sliding_log_rate_limiter.sv =====
// Sliding-window log rate limiter. Each input transfer carries one request
// stamped with a 32-bit wrapping millisecond time. The block keeps the times
// of accepted requests, oldest first, in a small RAM of LOG_DEPTH entries.
// For each request it walks the log one entry at a time, drops every entry
// whose wrapping age (now minus logged time) is not below window_ms and
// compacts the survivors in place, keeping their order. If the survivors
// number at least max_requests (clamped to LOG_DEPTH) the request is refused;
// otherwise its time is appended and it is allowed. Every request gives one
// output transfer with the verdict and the number of entries then held.
// For each request the controller takes the request, then, as the log RAM
// has one registered read port, reads each entry held (at most LOG_DEPTH)
// and then compares and writes it back as a separate step, and at the end
// decides, waiting while the output register is full. One request is worked
// on at a time; the input stalls from acceptance until the verdict is placed
// in the output register, and the next request is taken while that verdict
// still waits for the downstream side. Configuration writes (index 0 for
// window_ms, index 1 for max_requests, others ignored) take effect at once and
// should only be made while the block is idle. After reset the window is
// 1000 ms, the maximum is 10 and the log is empty; no clearing pass is needed.

`default_nettype none

module sliding_log_rate_limiter #(
    parameter int LOG_DEPTH = sllr_pkg::DEF_LOG_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request channel.
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [sllr_pkg::TIME_W-1:0]     i_now_ms,
    // Verdict channel.
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_allowed,
    output logic [sllr_pkg::HELD_W-1:0]          o_entries_held,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic [sllr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sllr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import sllr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller sequences the walk over the log; it sees the request valid
    // and the status flags and drives the command strobes and the input stall.
    sllr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the configuration, the log RAM, the scan pointers
    // and the output register.
    sllr_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_now_ms       (i_now_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_allowed      (o_allowed),
        .o_entries_held (o_entries_held)
    );

endmodule

`default_nettype wire
